// ----- rtl/asdid_pkg.sv -----
`timescale 1ns / 1ps
package asdid_pkg;

   typedef enum logic [2:0] {
      FN_APPEND = 3'd0,
      FN_SORT   = 3'd1,
      FN_DEDUP  = 3'd2,
      FN_INSERT = 3'd3,
      FN_DELETE = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_BAD_POS   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SORT_RDI,
      S_SORT_RDJ,
      S_SORT_CMP,
      S_SORT_WB,
      S_DD_RDR,
      S_DD_RDS,
      S_DD_CMP,
      S_INS_RD,
      S_INS_WR,
      S_DEL_RD,
      S_DEL_CMP,
      S_DEL_SH,
      S_EMIT_RD,
      S_EMIT_WAIT
   } state_type;

endpackage

// ----- rtl/array_sort_dedup_insert_delete_unit.sv -----
`timescale 1ns / 1ps
// Array sort / dedup / insert / delete unit.
// One request beat (req_tdata) carries an operation, a value and a position.
// Append stores the value at the end (dropped when full) and produces nothing.
// Sort, dedup, insert and delete each answer with the resulting array as a run
// of response beats, one per element, with rsp_tlast on the final beat; an
// empty array answers with a single beat of element 0, count 0.
// Every element carries the new count and the operation status.
// Codes 5 to 7 are ignored.
// All storage sits in one RAM with a write port and a registered read port; a
// sequencer walks it. Sort is an exchange sort that compares each element
// against every later one; dedup checks each element against the kept entries;
// insert and delete shift entries one at a time; the run emits one beat at a
// time. The unit handles one request at a time: req_tready is high only while
// idle.
// A stalled receiver (rsp_tready low) holds the current beat in the output
// register and the sequencer waits; nothing is lost.
// Synchronous reset empties the array (the count goes to zero); RAM contents
// are not cleared, since only entries below the count are ever read.
module array_sort_dedup_insert_delete_unit #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] func, [34:3] value, [40:35] position, [47:41] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] element, [37:32] count, [39:38] status
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic [31:0] mem [CAPACITY];
   logic [31:0] rdata;
   logic [AW-1:0] raddr, waddr;
   logic          wen;
   logic [31:0]   wdata;

   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end

   asdid_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [31:0] a_ff, a_in, val_ff, val_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [1:0] st_ff, st_in;
   logic ov_ff, ov_in, olast_ff, olast_in;
   logic [31:0] oel_ff, oel_in;
   logic [CW-1:0] ocnt_ff, ocnt_in;
   logic [1:0] ost_ff, ost_in;

   logic [2:0] r_func;
   logic [31:0] r_val;
   logic [5:0] r_pos;
   assign r_func = req_tdata[2:0];
   assign r_val  = req_tdata[34:3];
   assign r_pos  = req_tdata[40:35];
   assign req_tready = (state_ff == asdid_pkg::S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asdid_pkg::S_IDLE;
         cnt_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ov_ff <= ov_in;
      end
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; a_ff <= a_in; val_ff <= val_in;
      pos_ff <= pos_in; st_ff <= st_in; olast_ff <= olast_in; oel_ff <= oel_in;
      ocnt_ff <= ocnt_in; ost_ff <= ost_in;
   end

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff;
      a_in = a_ff; val_in = val_ff; pos_in = pos_ff; st_in = st_ff;
      ov_in = ov_ff; olast_in = olast_ff; oel_in = oel_ff; ocnt_in = ocnt_ff;
      ost_in = ost_ff;
      raddr = i_ff[AW-1:0]; waddr = i_ff[AW-1:0]; wen = 1'b0; wdata = a_ff;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (state_ff)
         asdid_pkg::S_IDLE: begin
            if (req_tvalid) begin
               val_in = r_val;
               pos_in = CW'(r_pos);
               st_in = asdid_pkg::ST_OK;
               i_in = '0;
               case (r_func)
                  asdid_pkg::FN_APPEND: begin
                     if (cnt_ff < CW'(CAPACITY)) begin
                        wen = 1'b1; waddr = cnt_ff[AW-1:0]; wdata = r_val;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  asdid_pkg::FN_SORT: state_in = asdid_pkg::S_SORT_RDI;
                  asdid_pkg::FN_DEDUP: begin
                     j_in = '0; state_in = asdid_pkg::S_DD_RDR;
                  end
                  asdid_pkg::FN_INSERT: begin
                     if (cnt_ff >= CW'(CAPACITY)) begin
                        st_in = asdid_pkg::ST_FULL; state_in = asdid_pkg::S_EMIT_RD;
                     end else if (r_pos == 6'd0 || CW'(r_pos) > cnt_ff ||
                                  (CW > 6 ? 1'b0 : r_pos > 6'(cnt_ff))) begin
                        st_in = asdid_pkg::ST_BAD_POS; state_in = asdid_pkg::S_EMIT_RD;
                     end else begin
                        i_in = cnt_ff; state_in = asdid_pkg::S_INS_RD;
                     end
                  end
                  asdid_pkg::FN_DELETE: state_in = asdid_pkg::S_DEL_RD;
                  default: ;
               endcase
            end
         end
         // exchange sort: a = elem[i], compare with elem[j]
         asdid_pkg::S_SORT_RDI: begin
            if (i_ff + 1'b1 >= cnt_ff) begin
               i_in = '0; state_in = asdid_pkg::S_EMIT_RD;
            end else begin
               raddr = i_ff[AW-1:0]; j_in = i_ff + 1'b1;
               state_in = asdid_pkg::S_SORT_RDJ;
            end
         end
         asdid_pkg::S_SORT_RDJ: begin
            if (j_ff == i_ff + 1'b1) a_in = rdata;
            raddr = j_ff[AW-1:0];
            state_in = asdid_pkg::S_SORT_CMP;
         end
         asdid_pkg::S_SORT_CMP: begin
            if ($signed(a_ff) > $signed(rdata)) begin
               wen = 1'b1; waddr = j_ff[AW-1:0]; wdata = a_ff; a_in = rdata;
            end
            if (j_ff + 1'b1 >= cnt_ff) begin
               state_in = asdid_pkg::S_SORT_WB;
               j_in = '0;
            end else begin
               j_in = j_ff + 1'b1; state_in = asdid_pkg::S_SORT_RDJ;
            end
         end
         // store the running minimum back at i
         asdid_pkg::S_SORT_WB: begin
            wen = 1'b1; waddr = i_ff[AW-1:0]; wdata = a_ff;
            i_in = i_ff + 1'b1; state_in = asdid_pkg::S_SORT_RDI;
         end
         // dedup: i = read index r, j = kept, k = scan s
         asdid_pkg::S_DD_RDR: begin
            if (i_ff >= cnt_ff) begin
               cnt_in = j_ff; i_in = '0; state_in = asdid_pkg::S_EMIT_RD;
            end else begin
               raddr = i_ff[AW-1:0]; k_in = '0; state_in = asdid_pkg::S_DD_RDS;
            end
         end
         asdid_pkg::S_DD_RDS: begin
            if (k_ff == '0) a_in = rdata;
            if (k_ff >= j_ff) begin
               wen = 1'b1; waddr = j_ff[AW-1:0];
               wdata = (k_ff == '0) ? rdata : a_ff;
               j_in = j_ff + 1'b1; i_in = i_ff + 1'b1;
               state_in = asdid_pkg::S_DD_RDR;
            end else begin
               raddr = k_ff[AW-1:0]; state_in = asdid_pkg::S_DD_CMP;
            end
         end
         asdid_pkg::S_DD_CMP: begin
            if (rdata == a_ff) begin
               i_in = i_ff + 1'b1; state_in = asdid_pkg::S_DD_RDR;
            end else begin
               k_in = k_ff + 1'b1; state_in = asdid_pkg::S_DD_RDS;
            end
         end
         // insert: shift from top down to slot pos-1
         asdid_pkg::S_INS_RD: begin
            if (i_ff == pos_ff - 1'b1) begin
               wen = 1'b1; waddr = i_ff[AW-1:0]; wdata = val_ff;
               cnt_in = cnt_ff + 1'b1; i_in = '0; state_in = asdid_pkg::S_EMIT_RD;
            end else begin
               raddr = AW'(i_ff - 1'b1); state_in = asdid_pkg::S_INS_WR;
            end
         end
         asdid_pkg::S_INS_WR: begin
            wen = 1'b1; waddr = i_ff[AW-1:0]; wdata = rdata;
            i_in = i_ff - 1'b1; state_in = asdid_pkg::S_INS_RD;
         end
         // delete: find, then shift down
         asdid_pkg::S_DEL_RD: begin
            if (i_ff >= cnt_ff) begin
               st_in = asdid_pkg::ST_NOT_FOUND; i_in = '0;
               state_in = asdid_pkg::S_EMIT_RD;
            end else begin
               raddr = i_ff[AW-1:0]; state_in = asdid_pkg::S_DEL_CMP;
            end
         end
         asdid_pkg::S_DEL_CMP: begin
            if (rdata == val_ff) state_in = asdid_pkg::S_DEL_SH;
            else begin
               i_in = i_ff + 1'b1; state_in = asdid_pkg::S_DEL_RD;
            end
         end
         asdid_pkg::S_DEL_SH: begin
            // read i+1, then write it back to i in S_EMIT_WAIT
            if (i_ff + 1'b1 >= cnt_ff) begin
               cnt_in = cnt_ff - 1'b1; i_in = '0; state_in = asdid_pkg::S_EMIT_RD;
            end else begin
               raddr = AW'(i_ff + 1'b1); k_in = i_ff; state_in = asdid_pkg::S_INS_WR;
               state_in = asdid_pkg::S_EMIT_WAIT;
               j_in = '1;
            end
         end
         asdid_pkg::S_EMIT_RD: begin
            if (!ov_ff || rsp_tready) begin
               raddr = i_ff[AW-1:0]; j_in = '0; state_in = asdid_pkg::S_EMIT_WAIT;
            end
         end
         asdid_pkg::S_EMIT_WAIT: begin
            if (j_ff == '1 && CW > 0) begin
               // delete shift write-back
               wen = 1'b1; waddr = i_ff[AW-1:0]; wdata = rdata;
               i_in = i_ff + 1'b1; state_in = asdid_pkg::S_DEL_SH;
            end else begin
               ov_in = 1'b1;
               oel_in = (cnt_ff == '0) ? 32'd0 : rdata;
               ocnt_in = cnt_ff; ost_in = st_ff;
               olast_in = (cnt_ff == '0) || (i_ff + 1'b1 == cnt_ff);
               if (olast_in) state_in = asdid_pkg::S_IDLE;
               else begin
                  i_in = i_ff + 1'b1; state_in = asdid_pkg::S_EMIT_RD;
               end
            end
         end
         default: state_in = asdid_pkg::S_IDLE;
      endcase
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {ost_ff, 6'(ocnt_ff), oel_ff};

   // A held beat keeps its payload while stalled.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed under stall");
   // The count never exceeds capacity.
   a_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("count above capacity");
   // Requests are taken only while idle.
   a_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == asdid_pkg::S_IDLE)
      else $error("ready outside idle");
endmodule
